[src/eht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eht_pkg;

   localparam int MAX_GLOBAL_DEPTH = 6;
   localparam int SLOTS_PER_BUCKET = 4;
   localparam int KEY_BITS         = 32;
   localparam int VALUE_BITS       = 32;

   localparam int IDX_W       = MAX_GLOBAL_DEPTH;
   localparam int DIR_ENTRIES = 1 << IDX_W;
   localparam int DEPTH_W     = 3;
   localparam int FILL_W      = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int SLOT_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int VALID_BITS  = DIR_ENTRIES * SLOTS_PER_BUCKET;
   localparam int META_AW     = IDX_W + 1;
   localparam int META_DW     = IDX_W;
   localparam int CNT_W       = IDX_W + 2;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int CFG_W       = 3;

   // request actions
   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_UPDATE = 3'd2;
   localparam logic [2:0] ACT_SEARCH = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   // result status
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_EXISTS  = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // remove modes
   localparam logic [1:0] RM_LAZY   = 2'd0;
   localparam logic [1:0] RM_SHRINK = 2'd2;

   // meta memory regions (top address bit)
   localparam logic META_DIR   = 1'b0;
   localparam logic META_DEPTH = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_BUCKET_CAPACITY = 1'b0;
   localparam logic CSR_INITIAL_DEPTH   = 1'b1;

   typedef struct packed {
      logic [2:0]            action;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value_in;
      logic [1:0]            remove_mode;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] value_out;
      logic [IDX_W-1:0]      bucket_index;
      logic [DEPTH_W-1:0]    bucket_depth;
      logic [DEPTH_W-1:0]    table_depth;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } slot_entry_type;

   typedef slot_entry_type [SLOTS_PER_BUCKET-1:0] slot_row_type;

   typedef struct packed {
      logic               rd_en;
      logic [META_AW-1:0] rd_addr;
      logic               wr_en;
      logic [META_AW-1:0] wr_addr;
      logic [META_DW-1:0] wr_data;
   } meta_cmd_type;

   typedef struct packed {
      logic                        rd_en;
      logic [IDX_W-1:0]            rd_addr;
      logic                        wr_en;
      logic [IDX_W-1:0]            wr_addr;
      logic [SLOTS_PER_BUCKET-1:0] wr_mask;
      slot_row_type                wr_data;
   } slot_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DIR, S_ROW, S_EVAL, S_SPLIT, S_SPLIT2, S_SPLIT3,
      S_MRG0, S_MRG1, S_MRG2, S_SHR, S_CLR, S_WALK,
      S_FIN0, S_FIN1, S_FIN2, S_SEND
   } state_type;

   typedef enum logic [2:0] {
      W_DOUBLE, W_REMAP, W_MERGE, W_SHRINK, W_CLEAR
   } walk_type;

endpackage

`default_nettype wire

[src/eht_meta_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

// directory entries in the low half, bucket local depths in the high half
module eht_meta_mem import eht_pkg::*; (
   input  wire logic               clock,
   input  wire meta_cmd_type       cmd,
   output logic [META_DW-1:0]      rd_data
);

   logic [META_DW-1:0] mem [2**META_AW];
   logic [META_DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/eht_slot_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

// one row per bucket, per-slot write enables
module eht_slot_mem import eht_pkg::*; (
   input  wire logic         clock,
   input  wire slot_cmd_type cmd,
   output slot_row_type      rd_data
);

   slot_row_type mem [DIR_ENTRIES];
   slot_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         if (cmd.wr_en && cmd.wr_mask[s]) begin
            mem[cmd.wr_addr][s] <= cmd.wr_data[s];
         end
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/eht_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module eht_seq import eht_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire req_type            req_payload,
   output logic                    req_stall,
   input  wire logic [CFG_W-1:0]   cap_cfg,
   input  wire logic [CFG_W-1:0]   init_cfg,
   input  wire logic               rsp_free,
   output logic                    res_valid,
   output rsp_type                 res_payload,
   output meta_cmd_type            meta_cmd,
   input  wire logic [META_DW-1:0] meta_rd_data,
   output slot_cmd_type            slot_cmd,
   input  wire slot_row_type       slot_rd_data
);

   state_type                   state_ff, state_in;
   walk_type                    kind_ff, kind_in;
   logic                        boot_ff, boot_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            limit_ff, limit_in;
   logic                        pend_ff, pend_in;
   logic [IDX_W-1:0]            addr_d_ff, addr_d_in;
   logic                        hit_ff, hit_in;
   req_type                     op_ff, op_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            bucket_ff, bucket_in;
   logic [DEPTH_W-1:0]          bdepth_ff, bdepth_in;
   logic [DEPTH_W-1:0]          newd_ff, newd_in;
   logic [IDX_W-1:0]            nb_ff, nb_in;
   logic [IDX_W-1:0]            pb_ff, pb_in;
   logic [1:0]                  status_ff, status_in;
   logic [VALUE_BITS-1:0]       found_ff, found_in;
   logic [DEPTH_W-1:0]          clr_depth_ff, clr_depth_in;
   logic [DEPTH_W-1:0]          fdepth_ff, fdepth_in;
   logic [DEPTH_W-1:0]          dir_depth_ff, dir_depth_in;
   logic [DIR_ENTRIES-1:0]      in_use_ff, in_use_in;
   logic [VALID_BITS-1:0]       valid_ff, valid_in;

   logic [IDX_W-1:0]            dd_mask;
   logic [IDX_W-1:0]            key_idx;
   logic [CNT_W-1:0]            dir_span;
   logic [DEPTH_W-1:0]          depth_rd;
   logic [SLOTS_PER_BUCKET-1:0] vrow;
   logic                        hit_any;
   logic [SLOT_W-1:0]           hit_slot;
   logic [SLOT_W-1:0]           free_slot;
   logic [FILL_W-1:0]           fill;
   logic [FILL_W-1:0]           fill_after;
   logic [FILL_W-1:0]           cap_eff;
   logic [DEPTH_W-1:0]          init_eff;
   logic [IDX_W-1:0]            free_bkt;
   logic                        all_used;
   logic                        no_split;
   logic                        want_merge;
   logic                        pair_ok;
   logic                        walk_done;
   logic [DEPTH_W-1:0]          split_bit;
   logic [SLOTS_PER_BUCKET-1:0] mv;
   slot_row_type                nb_row;
   logic [SLOTS_PER_BUCKET-1:0] nb_valid;
   slot_row_type                put_row;

   assign dir_span  = CNT_W'(1) << dir_depth_ff;
   assign dd_mask   = IDX_W'(dir_span - CNT_W'(1));
   assign key_idx   = op_ff.key[IDX_W-1:0] & dd_mask;
   assign depth_rd  = meta_rd_data[DEPTH_W-1:0];
   assign vrow      = valid_ff[int'(bucket_ff) * SLOTS_PER_BUCKET +: SLOTS_PER_BUCKET];
   assign fill      = FILL_W'($countones(vrow));
   assign fill_after = fill - FILL_W'(hit_any);
   assign all_used  = &in_use_ff;
   assign no_split  = (int'(depth_rd) >= MAX_GLOBAL_DEPTH) || all_used;
   assign want_merge = (op_ff.remove_mode != RM_LAZY) && (fill_after == '0)
                       && (depth_rd > DEPTH_W'(1)) && (depth_rd <= dir_depth_ff);
   assign pair_ok   = (pb_ff != bucket_ff) && (depth_rd == bdepth_ff);
   assign walk_done = (cnt_ff >= limit_ff) && !pend_ff;
   assign split_bit = newd_ff - DEPTH_W'(1);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      if (cap_cfg == '0) begin
         cap_eff = FILL_W'(1);
      end else if (int'(cap_cfg) > SLOTS_PER_BUCKET) begin
         cap_eff = FILL_W'(SLOTS_PER_BUCKET);
      end else begin
         cap_eff = FILL_W'(cap_cfg);
      end
      if (init_cfg == '0) begin
         init_eff = DEPTH_W'(1);
      end else if (int'(init_cfg) > MAX_GLOBAL_DEPTH) begin
         init_eff = DEPTH_W'(MAX_GLOBAL_DEPTH);
      end else begin
         init_eff = init_cfg;
      end
   end

   // key match and first free slot in the row just read
   always_comb begin
      hit_any   = 1'b0;
      hit_slot  = '0;
      free_slot = '0;
      for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
         if (vrow[s] && (slot_rd_data[s].key == op_ff.key)) begin
            hit_any  = 1'b1;
            hit_slot = SLOT_W'(s);
         end
         if (!vrow[s]) begin
            free_slot = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      free_bkt = '0;
      for (int i = DIR_ENTRIES - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_bkt = IDX_W'(i);
         end
      end
   end

   // split: entries whose split bit differs go, packed, to the new bucket
   always_comb begin
      logic [FILL_W-1:0] n;
      n        = '0;
      nb_row   = slot_rd_data;
      nb_valid = '0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         mv[s] = vrow[s] && (slot_rd_data[s].key[split_bit] != idx_ff[split_bit]);
         if (mv[s]) begin
            nb_row[n[SLOT_W-1:0]]   = slot_rd_data[s];
            nb_valid[n[SLOT_W-1:0]] = 1'b1;
            n = FILL_W'(n + 1'b1);
         end
      end
   end

   always_comb begin
      put_row = slot_rd_data;
      put_row[hit_any ? hit_slot : free_slot] = {op_ff.key, op_ff.value_in};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_payload.action == ACT_CLEAR) begin
                  state_in = S_CLR;
               end else if (req_payload.action inside {ACT_INSERT, ACT_REMOVE,
                                                      ACT_UPDATE, ACT_SEARCH}) begin
                  state_in = S_DIR;
               end else begin
                  state_in = S_FIN0;
               end
            end
         end
         S_DIR:  state_in = S_ROW;
         S_ROW:  state_in = S_EVAL;
         S_EVAL: begin
            if (op_ff.action == ACT_INSERT) begin
               if (hit_any || (fill < cap_eff) || no_split) begin
                  state_in = S_FIN0;
               end else begin
                  state_in = S_SPLIT;
               end
            end else if (op_ff.action == ACT_REMOVE) begin
               state_in = want_merge ? S_MRG0 : S_SHR;
            end else begin
               state_in = S_FIN0;
            end
         end
         S_SPLIT:  state_in = (newd_ff > dir_depth_ff) ? S_WALK : S_SPLIT2;
         S_SPLIT2: state_in = S_SPLIT3;
         S_SPLIT3: state_in = S_WALK;
         S_MRG0:   state_in = S_MRG1;
         S_MRG1:   state_in = S_MRG2;
         S_MRG2:   state_in = pair_ok ? S_WALK : S_SHR;
         S_SHR: begin
            if ((op_ff.remove_mode >= RM_SHRINK) && (dir_depth_ff > DEPTH_W'(1))) begin
               state_in = S_WALK;
            end else begin
               state_in = S_FIN0;
            end
         end
         S_CLR: state_in = S_WALK;
         S_WALK: begin
            if (walk_done) begin
               case (kind_ff)
                  W_DOUBLE: state_in = S_SPLIT2;
                  W_REMAP:  state_in = S_DIR;
                  W_MERGE:  state_in = S_SHR;
                  W_SHRINK: state_in = S_FIN0;
                  W_CLEAR:  state_in = boot_ff ? S_IDLE : S_FIN0;
                  default:  state_in = S_FIN0;
               endcase
            end
         end
         S_FIN0: state_in = S_FIN1;
         S_FIN1: state_in = S_FIN2;
         S_FIN2: state_in = S_SEND;
         S_SEND: state_in = rsp_free ? S_IDLE : S_SEND;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory commands
   always_comb begin
      kind_in      = kind_ff;
      boot_in      = boot_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      pend_in      = pend_ff;
      addr_d_in    = addr_d_ff;
      hit_in       = hit_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      bucket_in    = bucket_ff;
      bdepth_in    = bdepth_ff;
      newd_in      = newd_ff;
      nb_in        = nb_ff;
      pb_in        = pb_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      clr_depth_in = clr_depth_ff;
      fdepth_in    = fdepth_ff;
      dir_depth_in = dir_depth_ff;
      in_use_in    = in_use_ff;
      valid_in     = valid_ff;
      meta_cmd     = '0;
      slot_cmd     = '0;
      res_valid    = 1'b0;
      res_payload  = {status_ff, found_ff, idx_ff, fdepth_ff, dir_depth_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_payload;
               status_in = ST_DONE;
               found_in  = '0;
            end
         end
         S_DIR: begin
            idx_in           = key_idx;
            meta_cmd.rd_en   = 1'b1;
            meta_cmd.rd_addr = {META_DIR, key_idx};
         end
         S_ROW: begin
            bucket_in        = meta_rd_data[IDX_W-1:0];
            meta_cmd.rd_en   = 1'b1;
            meta_cmd.rd_addr = {META_DEPTH, meta_rd_data[IDX_W-1:0]};
            slot_cmd.rd_en   = 1'b1;
            slot_cmd.rd_addr = meta_rd_data[IDX_W-1:0];
         end
         S_EVAL: begin
            bdepth_in = depth_rd;
            if (op_ff.action == ACT_INSERT) begin
               if (hit_any) begin
                  status_in = ST_EXISTS;
               end else if (fill < cap_eff) begin
                  slot_cmd.wr_en   = 1'b1;
                  slot_cmd.wr_addr = bucket_ff;
                  slot_cmd.wr_mask = SLOTS_PER_BUCKET'(1) << free_slot;
                  slot_cmd.wr_data = put_row;
                  valid_in[int'(bucket_ff) * SLOTS_PER_BUCKET + int'(free_slot)] = 1'b1;
               end else if (no_split) begin
                  status_in = ST_FULL;
               end else begin
                  nb_in   = free_bkt;
                  newd_in = depth_rd + DEPTH_W'(1);
               end
            end else if (op_ff.action == ACT_REMOVE) begin
               if (hit_any) begin
                  valid_in[int'(bucket_ff) * SLOTS_PER_BUCKET + int'(hit_slot)] = 1'b0;
               end else begin
                  status_in = ST_MISSING;
               end
            end else begin
               if (!hit_any) begin
                  status_in = ST_MISSING;
               end else if (op_ff.action == ACT_UPDATE) begin
                  slot_cmd.wr_en   = 1'b1;
                  slot_cmd.wr_addr = bucket_ff;
                  slot_cmd.wr_mask = SLOTS_PER_BUCKET'(1) << hit_slot;
                  slot_cmd.wr_data = put_row;
               end else begin
                  found_in = slot_rd_data[hit_slot].value;
               end
            end
         end
         S_SPLIT: begin
            if (newd_ff > dir_depth_ff) begin
               kind_in  = W_DOUBLE;
               cnt_in   = '0;
               limit_in = dir_span;
               pend_in  = 1'b0;
            end
         end
         S_SPLIT2: begin
            meta_cmd.wr_en   = 1'b1;
            meta_cmd.wr_addr = {META_DEPTH, nb_ff};
            meta_cmd.wr_data = META_DW'(newd_ff);
            in_use_in[nb_ff] = 1'b1;
            slot_cmd.wr_en   = 1'b1;
            slot_cmd.wr_addr = nb_ff;
            slot_cmd.wr_mask = '1;
            slot_cmd.wr_data = nb_row;
            valid_in[int'(bucket_ff) * SLOTS_PER_BUCKET +: SLOTS_PER_BUCKET] = vrow & ~mv;
            valid_in[int'(nb_ff) * SLOTS_PER_BUCKET +: SLOTS_PER_BUCKET]     = nb_valid;
         end
         S_SPLIT3: begin
            meta_cmd.wr_en   = 1'b1;
            meta_cmd.wr_addr = {META_DEPTH, bucket_ff};
            meta_cmd.wr_data = META_DW'(newd_ff);
            kind_in  = W_REMAP;
            cnt_in   = '0;
            limit_in = dir_span;
            pend_in  = 1'b0;
         end
         S_MRG0: begin
            meta_cmd.rd_en   = 1'b1;
            meta_cmd.rd_addr = {META_DIR,
                                idx_ff ^ (IDX_W'(1) << (bdepth_ff - DEPTH_W'(1)))};
         end
         S_MRG1: begin
            pb_in            = meta_rd_data[IDX_W-1:0];
            meta_cmd.rd_en   = 1'b1;
            meta_cmd.rd_addr = {META_DEPTH, meta_rd_data[IDX_W-1:0]};
         end
         S_MRG2: begin
            if (pair_ok) begin
               meta_cmd.wr_en       = 1'b1;
               meta_cmd.wr_addr     = {META_DEPTH, pb_ff};
               meta_cmd.wr_data     = META_DW'(bdepth_ff - DEPTH_W'(1));
               in_use_in[bucket_ff] = 1'b0;
               kind_in  = W_MERGE;
               cnt_in   = '0;
               limit_in = dir_span;
               pend_in  = 1'b0;
            end
         end
         S_SHR: begin
            kind_in  = W_SHRINK;
            cnt_in   = '0;
            limit_in = CNT_W'(DIR_ENTRIES);
            pend_in  = 1'b0;
            hit_in   = 1'b0;
         end
         S_CLR: begin
            dir_depth_in = init_eff;
            clr_depth_in = init_eff;
            valid_in     = '0;
            for (int i = 0; i < DIR_ENTRIES; i++) begin
               in_use_in[i] = (CNT_W'(i) < (CNT_W'(1) << init_eff));
            end
            kind_in  = W_CLEAR;
            cnt_in   = '0;
            limit_in = CNT_W'(2 * DIR_ENTRIES);
            pend_in  = 1'b0;
         end
         S_WALK: begin
            pend_in = 1'b0;
            if (kind_ff == W_CLEAR) begin
               if (cnt_ff < limit_ff) begin
                  meta_cmd.wr_en   = 1'b1;
                  meta_cmd.wr_addr = cnt_ff[META_AW-1:0];
                  meta_cmd.wr_data = cnt_ff[IDX_W] ? META_DW'(clr_depth_ff)
                                                   : cnt_ff[IDX_W-1:0];
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end else begin
               if (cnt_ff < limit_ff) begin
                  meta_cmd.rd_en   = 1'b1;
                  meta_cmd.rd_addr = {(kind_ff == W_SHRINK) ? META_DEPTH : META_DIR,
                                      cnt_ff[IDX_W-1:0]};
                  cnt_in    = cnt_ff + CNT_W'(1);
                  pend_in   = 1'b1;
                  addr_d_in = cnt_ff[IDX_W-1:0];
               end
               if (pend_ff) begin
                  case (kind_ff)
                     W_DOUBLE: begin
                        meta_cmd.wr_en   = 1'b1;
                        meta_cmd.wr_addr = {META_DIR, addr_d_ff + IDX_W'(dir_span)};
                        meta_cmd.wr_data = meta_rd_data;
                     end
                     W_REMAP: begin
                        if ((meta_rd_data[IDX_W-1:0] == bucket_ff)
                            && (addr_d_ff[split_bit] != idx_ff[split_bit])) begin
                           meta_cmd.wr_en   = 1'b1;
                           meta_cmd.wr_addr = {META_DIR, addr_d_ff};
                           meta_cmd.wr_data = nb_ff;
                        end
                     end
                     W_MERGE: begin
                        if (meta_rd_data[IDX_W-1:0] == bucket_ff) begin
                           meta_cmd.wr_en   = 1'b1;
                           meta_cmd.wr_addr = {META_DIR, addr_d_ff};
                           meta_cmd.wr_data = pb_ff;
                        end
                     end
                     W_SHRINK: begin
                        if (in_use_ff[addr_d_ff] && (depth_rd >= dir_depth_ff)) begin
                           hit_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            if (walk_done) begin
               case (kind_ff)
                  W_DOUBLE: dir_depth_in = dir_depth_ff + DEPTH_W'(1);
                  W_SHRINK: begin
                     if (!hit_ff) begin
                        dir_depth_in = dir_depth_ff - DEPTH_W'(1);
                     end
                  end
                  W_CLEAR:  boot_in = 1'b0;
                  default: ;
               endcase
            end
         end
         S_FIN0: begin
            idx_in           = key_idx;
            meta_cmd.rd_en   = 1'b1;
            meta_cmd.rd_addr = {META_DIR, key_idx};
         end
         S_FIN1: begin
            meta_cmd.rd_en   = 1'b1;
            meta_cmd.rd_addr = {META_DEPTH, meta_rd_data[IDX_W-1:0]};
         end
         S_FIN2: begin
            fdepth_in = depth_rd;
         end
         S_SEND: begin
            res_valid = rsp_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WALK;
         kind_ff      <= W_CLEAR;
         boot_ff      <= 1'b1;
         cnt_ff       <= '0;
         limit_ff     <= CNT_W'(2 * DIR_ENTRIES);
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         clr_depth_ff <= DEPTH_W'(1);
         dir_depth_ff <= DEPTH_W'(1);
         in_use_ff    <= DIR_ENTRIES'(2'b11);
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         boot_ff      <= boot_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         clr_depth_ff <= clr_depth_in;
         dir_depth_ff <= dir_depth_in;
         in_use_ff    <= in_use_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_d_ff <= addr_d_in;
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      bucket_ff <= bucket_in;
      bdepth_ff <= bdepth_in;
      newd_ff   <= newd_in;
      nb_ff     <= nb_in;
      pb_ff     <= pb_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fdepth_ff <= fdepth_in;
   end

endmodule

`default_nettype wire

[src/extendible_hash_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each split rewrites the directory, after doubling it when the directory depth must grow; a
// merge rewrites it unless refused; a shrink check reads every local depth; a clear rewrites
// all of meta memory. Throughput: one request at a time; the next one is accepted the cycle
// after the result enters the output register.
// Reset: synchronous; a clearing pass then rebuilds the directory (req_stall high).

module extendible_hash_table_core import eht_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_payload,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_payload,
   // configuration port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0]      prdata,
   output logic                   pready
);

   logic [CFG_W-1:0] cap_ff;
   logic [CFG_W-1:0] init_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_payload_ff;

   meta_cmd_type     meta_cmd;
   logic [META_DW-1:0] meta_rd_data;
   slot_cmd_type     slot_cmd;
   slot_row_type     slot_rd_data;
   logic             res_valid;
   rsp_type          res_payload;
   logic             rsp_free;

   // registers: bucket capacity at 0x0, initial depth at 0x4
   assign pready = 1'b1;
   always_comb begin
      if (paddr[2] == CSR_INITIAL_DEPTH) begin
         prdata = CSR_DW'(init_ff);
      end else begin
         prdata = CSR_DW'(cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CFG_W'(4);
         init_ff <= CFG_W'(1);
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == CSR_BUCKET_CAPACITY) begin
            cap_ff <= pwdata[CFG_W-1:0];
         end else begin
            init_ff <= pwdata[CFG_W-1:0];
         end
      end
   end

   // result register: lets the sequencer take the next request while a result waits
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   eht_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_payload  (req_payload),
      .req_stall    (req_stall),
      .cap_cfg      (cap_ff),
      .init_cfg     (init_ff),
      .rsp_free     (rsp_free),
      .res_valid    (res_valid),
      .res_payload  (res_payload),
      .meta_cmd     (meta_cmd),
      .meta_rd_data (meta_rd_data),
      .slot_cmd     (slot_cmd),
      .slot_rd_data (slot_rd_data)
   );

   // directory and local depths
   eht_meta_mem u_meta_mem (
      .clock   (clock),
      .cmd     (meta_cmd),
      .rd_data (meta_rd_data)
   );

   // key/value slots, one row per bucket
   eht_slot_mem u_slot_mem (
      .clock   (clock),
      .cmd     (slot_cmd),
      .rd_data (slot_rd_data)
   );

endmodule

`default_nettype wire
